@@ rtl/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the point to segment distance unit.
// ----------------------------------------------------------------------------
package psd_pkg;

   // Default coordinate width in bits.
   localparam int COORD_WIDTH_DEFAULT = 32;

   // Closest region codes.
   typedef enum logic [1:0] {
      REGION_START        = 2'd0,
      REGION_INTERIOR     = 2'd1,
      REGION_END          = 2'd2,
      REGION_INTERIOR_END = 2'd3
   } region_type;

   // Control that travels with each item down the pipeline.
   typedef struct packed {
      logic       valid;
      region_type region;
      logic       sat;
   } tag_type;

endpackage

@@ rtl/psd_geom.sv @@
// ----------------------------------------------------------------------------
// psd_geom
// Six pipeline stages: differences, products, dot and cross sums, partial
// products of the wide squares, their assembly, and region selection with
// the numerator and denominator of the distance.
// ----------------------------------------------------------------------------
module psd_geom #(
   parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEFAULT,
   parameter int NW          = 4 * COORD_WIDTH + 8,
   parameter int DW          = 2 * COORD_WIDTH + 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [COORD_WIDTH-1:0] start_x,
   input  logic [COORD_WIDTH-1:0] start_y,
   input  logic [COORD_WIDTH-1:0] start_z,
   input  logic [COORD_WIDTH-1:0] end_x,
   input  logic [COORD_WIDTH-1:0] end_y,
   input  logic [COORD_WIDTH-1:0] end_z,
   input  logic [COORD_WIDTH-1:0] seg_len,
   input  logic [COORD_WIDTH-1:0] point_x,
   input  logic [COORD_WIDTH-1:0] point_y,
   input  logic [COORD_WIDTH-1:0] point_z,
   output psd_pkg::tag_type       tag_out,
   output logic [NW-1:0]          num_out,
   output logic [DW-1:0]          den_out
);
   localparam int W  = COORD_WIDTH;
   localparam int D  = W + 1;
   localparam int P  = 2 * D;
   localparam int SW = 2 * W + 4;
   localparam int CW = 2 * W + 3;
   localparam int LW = 4 * W + 4;
   localparam int QW = 2 * SW;
   localparam int XW = 2 * CW;
   localparam int H  = W + 1;
   localparam int MW = 2 * H;

   logic [5:0] valid_ff;

   // Valid bits move with the data whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // Stage 1: direction and offsets from both end points.
   logic signed [D-1:0] a_ff [0:2];
   logic signed [D-1:0] b_ff [0:2];
   logic signed [D-1:0] e_ff [0:2];
   logic [W-1:0]        len1_ff;
   logic [W-1:0]        sv [0:2];
   logic [W-1:0]        ev [0:2];
   logic [W-1:0]        pv [0:2];

   assign sv[0] = start_x;
   assign sv[1] = start_y;
   assign sv[2] = start_z;
   assign ev[0] = end_x;
   assign ev[1] = end_y;
   assign ev[2] = end_z;
   assign pv[0] = point_x;
   assign pv[1] = point_y;
   assign pv[2] = point_z;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= $signed({ev[i][W-1], ev[i]}) - $signed({sv[i][W-1], sv[i]});
            b_ff[i] <= $signed({pv[i][W-1], pv[i]}) - $signed({sv[i][W-1], sv[i]});
            e_ff[i] <= $signed({pv[i][W-1], pv[i]}) - $signed({ev[i][W-1], ev[i]});
         end
         len1_ff <= seg_len;
      end
   end

   // Stage 2: all component products.
   logic signed [P-1:0] ab_ff [0:2];
   logic signed [P-1:0] aa_ff [0:2];
   logic signed [P-1:0] bb_ff [0:2];
   logic signed [P-1:0] ee_ff [0:2];
   logic signed [P-1:0] cr_ff [0:5];
   logic [2*W-1:0]      len2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= a_ff[i] * b_ff[i];
            aa_ff[i] <= a_ff[i] * a_ff[i];
            bb_ff[i] <= b_ff[i] * b_ff[i];
            ee_ff[i] <= e_ff[i] * e_ff[i];
         end
         cr_ff[0] <= a_ff[1] * b_ff[2];
         cr_ff[1] <= a_ff[2] * b_ff[1];
         cr_ff[2] <= a_ff[2] * b_ff[0];
         cr_ff[3] <= a_ff[0] * b_ff[2];
         cr_ff[4] <= a_ff[0] * b_ff[1];
         cr_ff[5] <= a_ff[1] * b_ff[0];
         len2_ff  <= (2 * W)'(len1_ff) * (2 * W)'(len1_ff);
      end
   end

   // Stage 3: dot products and cross product components.
   logic signed [SW-1:0] dot3_ff;
   logic [SW-1:0]        aa3_ff;
   logic [SW-1:0]        bb3_ff;
   logic [SW-1:0]        ee3_ff;
   logic signed [CW-1:0] c3_ff [0:2];
   logic [2*W-1:0]       len3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dot3_ff <= SW'(ab_ff[0]) + SW'(ab_ff[1]) + SW'(ab_ff[2]);
         aa3_ff  <= $unsigned(SW'(aa_ff[0]) + SW'(aa_ff[1]) + SW'(aa_ff[2]));
         bb3_ff  <= $unsigned(SW'(bb_ff[0]) + SW'(bb_ff[1]) + SW'(bb_ff[2]));
         ee3_ff  <= $unsigned(SW'(ee_ff[0]) + SW'(ee_ff[1]) + SW'(ee_ff[2]));
         for (int i = 0; i < 3; i++) begin
            c3_ff[i] <= CW'(cr_ff[2*i]) - CW'(cr_ff[2*i+1]);
         end
         len3_ff <= len2_ff;
      end
   end

   // Stage 4: half-width partial products of the wide squares, plus flags.
   // A nonnegative dot product and the squared direction length both fit
   // in two halves; each cross component splits into a signed upper half
   // and an unsigned lower half.
   logic [MW-1:0]        dotm;
   logic [MW-1:0]        aam;
   logic [MW-1:0]        lenm;
   logic signed [H:0]    ch [0:2];
   logic [H-1:0]         cl [0:2];
   logic [MW-1:0]        dd_hh_ff;
   logic [MW-1:0]        dd_hl_ff;
   logic [MW-1:0]        dd_ll_ff;
   logic [MW-1:0]        la_hh_ff;
   logic [MW-1:0]        la_hl_ff;
   logic [MW-1:0]        la_lh_ff;
   logic [MW-1:0]        la_ll_ff;
   logic signed [MW+1:0] ch2_ff [0:2];
   logic signed [MW+1:0] chl_ff [0:2];
   logic [MW-1:0]        cl2_ff [0:2];
   logic [SW-1:0]        aa4_ff;
   logic [SW-1:0]        bb4_ff;
   logic [SW-1:0]        ee4_ff;
   logic                 dneg4_ff;
   logic                 aazero4_ff;
   logic                 farneg4_ff;

   assign dotm = dot3_ff[MW-1:0];
   assign aam  = aa3_ff[MW-1:0];
   assign lenm = MW'(len3_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ch[i] = c3_ff[i][CW-1:H];
         cl[i] = c3_ff[i][H-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dd_hh_ff <= dotm[MW-1:H] * dotm[MW-1:H];
         dd_hl_ff <= dotm[MW-1:H] * dotm[H-1:0];
         dd_ll_ff <= dotm[H-1:0] * dotm[H-1:0];
         la_hh_ff <= lenm[MW-1:H] * aam[MW-1:H];
         la_hl_ff <= lenm[MW-1:H] * aam[H-1:0];
         la_lh_ff <= lenm[H-1:0] * aam[MW-1:H];
         la_ll_ff <= lenm[H-1:0] * aam[H-1:0];
         for (int i = 0; i < 3; i++) begin
            ch2_ff[i] <= ch[i] * ch[i];
            chl_ff[i] <= ch[i] * $signed({1'b0, cl[i]});
            cl2_ff[i] <= cl[i] * cl[i];
         end
         aa4_ff     <= aa3_ff;
         bb4_ff     <= bb3_ff;
         ee4_ff     <= ee3_ff;
         dneg4_ff   <= dot3_ff[SW-1];
         aazero4_ff <= (aa3_ff == '0);
         // Seen from the end point the projection is aa - dot.
         farneg4_ff <= !dot3_ff[SW-1] && ($unsigned(dot3_ff) > aa3_ff);
      end
   end

   // Stage 5: assemble the squares for the interior test and the cross product.
   logic [QW-1:0]        dot2_ff;
   logic [LW-1:0]        lim_ff;
   logic [XW-1:0]        csq_ff [0:2];
   logic [SW-1:0]        aa5_ff;
   logic [SW-1:0]        bb5_ff;
   logic [SW-1:0]        ee5_ff;
   logic                 dneg_ff;
   logic                 aazero_ff;
   logic                 farneg_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dot2_ff <= (QW'(dd_hh_ff) << (2 * H)) + (QW'(dd_hl_ff) << (H + 1))
                    + QW'(dd_ll_ff);
         lim_ff  <= (LW'(la_hh_ff) << (2 * H)) + ((LW'(la_hl_ff) + LW'(la_lh_ff)) << H)
                    + LW'(la_ll_ff);
         for (int i = 0; i < 3; i++) begin
            csq_ff[i] <= $unsigned((XW'(ch2_ff[i]) << (2 * H))
                                   + (XW'(chl_ff[i]) << (H + 1)) + XW'(cl2_ff[i]));
         end
         aa5_ff    <= aa4_ff;
         bb5_ff    <= bb4_ff;
         ee5_ff    <= ee4_ff;
         dneg_ff   <= dneg4_ff;
         aazero_ff <= aazero4_ff;
         farneg_ff <= farneg4_ff;
      end
   end

   // Stage 6: pick the region and what the root is taken of.
   logic [NW-1:0]       cs;
   logic                in_range;
   psd_pkg::region_type region_in;
   logic [NW-1:0]       num_in;
   logic [DW-1:0]       den_in;

   assign cs       = NW'(csq_ff[0]) + NW'(csq_ff[1]) + NW'(csq_ff[2]);
   assign in_range = NW'(dot2_ff) <= NW'(lim_ff);

   always_comb begin
      priority if (dneg_ff) begin
         region_in = psd_pkg::REGION_START;
         num_in    = NW'(bb5_ff);
         den_in    = DW'(1);
      end else if (aazero_ff) begin
         region_in = psd_pkg::REGION_INTERIOR;
         num_in    = NW'(bb5_ff);
         den_in    = DW'(1);
      end else if (in_range) begin
         region_in = psd_pkg::REGION_INTERIOR;
         num_in    = cs;
         den_in    = DW'(aa5_ff);
      end else if (farneg_ff) begin
         region_in = psd_pkg::REGION_END;
         num_in    = NW'(ee5_ff);
         den_in    = DW'(1);
      end else begin
         // The cross product seen from the end point has the same magnitude.
         region_in = psd_pkg::REGION_INTERIOR_END;
         num_in    = cs;
         den_in    = DW'(aa5_ff);
      end
   end

   psd_pkg::region_type region_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         region_ff <= region_in;
         num_out   <= num_in;
         den_out   <= den_in;
      end
   end

   assign tag_out.valid  = valid_ff[5];
   assign tag_out.region = region_ff;
   assign tag_out.sat    = 1'b0;

endmodule

@@ rtl/psd_div_stage.sv @@
// ----------------------------------------------------------------------------
// psd_div_stage
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module psd_div_stage #(
   parameter int NW    = 136,
   parameter int DW    = 68,
   parameter int QW    = 64,
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  psd_pkg::tag_type tag_in,
   input  logic [NW-1:0]    rem_in,
   input  logic [DW-1:0]    den_in,
   input  logic [QW:0]      quo_in,
   output psd_pkg::tag_type tag_out,
   output logic [NW-1:0]    rem_out,
   output logic [DW-1:0]    den_out,
   output logic [QW:0]      quo_out
);
   logic [NW-1:0] dsh;
   logic          fits;

   assign dsh  = NW'(den_in) << SHIFT;
   assign fits = rem_in >= dsh;

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_out.valid <= 1'b0;
      end else if (advance) begin
         tag_out.valid <= tag_in.valid;
      end
   end

   // Subtract the shifted divisor where it fits.
   always_ff @(posedge clock) begin
      if (advance) begin
         tag_out.region <= tag_in.region;
         tag_out.sat    <= tag_in.sat;
         den_out        <= den_in;
         rem_out        <= fits ? rem_in - dsh : rem_in;
         quo_out        <= fits ? quo_in | ((QW + 1)'(1) << SHIFT) : quo_in;
      end
   end

endmodule

@@ rtl/psd_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// psd_sqrt_stage
// One digit-by-digit integer square root step: one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt_stage #(
   parameter int QW    = 64,
   parameter int RW    = 32,
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  psd_pkg::tag_type tag_in,
   input  logic [QW-1:0]    rem_in,
   input  logic [RW-1:0]    root_in,
   output psd_pkg::tag_type tag_out,
   output logic [QW-1:0]    rem_out,
   output logic [RW-1:0]    root_out
);
   logic [QW:0] trial;
   logic        fits;

   // (2r + 2^i) * 2^i, the growth of r^2 when bit i is set.
   assign trial = ((QW + 1)'(root_in) << (SHIFT + 1)) + ((QW + 1)'(1) << (2 * SHIFT));
   assign fits  = {1'b0, rem_in} >= trial;

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_out.valid <= 1'b0;
      end else if (advance) begin
         tag_out.valid <= tag_in.valid;
      end
   end

   // Accept the root bit where the remainder allows it.
   always_ff @(posedge clock) begin
      if (advance) begin
         tag_out.region <= tag_in.region;
         tag_out.sat    <= tag_in.sat;
         rem_out        <= fits ? rem_in - trial[QW-1:0] : rem_in;
         root_out       <= fits ? root_in | (RW'(1) << SHIFT) : root_in;
      end
   end

endmodule

@@ rtl/point_segment_distance_unit.sv @@
// ----------------------------------------------------------------------------
// point_segment_distance_unit
// Distance from a query point to a 3D segment, with closest region code.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle while the output is not stalled and
// passes it through six geometry stages, 2 * COORD_WIDTH + 1 restoring
// division stages that form the squared distance and detect saturation,
// and COORD_WIDTH square root stages, one result bit each. The whole
// pipeline holds while a result waits on the output, so req_tready is
// low only when a result waits with rsp_tready low. No state carries
// between items. The fraction position does not affect the arithmetic,
// since the root of a squared raw distance is a raw value at the same scale.
module point_segment_distance_unit #(
   parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, segment_length,
   // point_x, point_y, point_z, from the lowest bit up
   input  logic [((10*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // distance, region, from the lowest bit up
   output logic [((COORD_WIDTH+2+7)/8)*8-1:0]        rsp_tdata
);
   localparam int W   = COORD_WIDTH;
   localparam int NW  = 4 * W + 8;
   localparam int DW  = 2 * W + 4;
   localparam int QW  = 2 * W;
   localparam int ND  = QW + 1;
   localparam int OTW = ((W + 2 + 7) / 8) * 8;

   logic advance;

   // The pipeline moves unless a finished result is waiting.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Geometry front end.
   psd_pkg::tag_type geo_tag;
   logic [NW-1:0]    geo_num;
   logic [DW-1:0]    geo_den;

   psd_geom #(.COORD_WIDTH(W), .NW(NW), .DW(DW)) u_geom (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .start_x  (req_tdata[0*W +: W]),
      .start_y  (req_tdata[1*W +: W]),
      .start_z  (req_tdata[2*W +: W]),
      .end_x    (req_tdata[3*W +: W]),
      .end_y    (req_tdata[4*W +: W]),
      .end_z    (req_tdata[5*W +: W]),
      .seg_len  (req_tdata[6*W +: W]),
      .point_x  (req_tdata[7*W +: W]),
      .point_y  (req_tdata[8*W +: W]),
      .point_z  (req_tdata[9*W +: W]),
      .tag_out  (geo_tag),
      .num_out  (geo_num),
      .den_out  (geo_den)
   );

   // Division chain; the top quotient bit flags a distance that saturates.
   psd_pkg::tag_type div_tag [0:ND];
   logic [NW-1:0]    div_rem [0:ND];
   logic [DW-1:0]    div_den [0:ND];
   logic [QW:0]      div_quo [0:ND];

   assign div_tag[0] = geo_tag;
   assign div_rem[0] = geo_num;
   assign div_den[0] = geo_den;
   assign div_quo[0] = '0;

   for (genvar k = 0; k < ND; k++) begin : g_div
      psd_div_stage #(.NW(NW), .DW(DW), .QW(QW), .SHIFT(QW - k)) u_div (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tag_in  (div_tag[k]),
         .rem_in  (div_rem[k]),
         .den_in  (div_den[k]),
         .quo_in  (div_quo[k]),
         .tag_out (div_tag[k+1]),
         .rem_out (div_rem[k+1]),
         .den_out (div_den[k+1]),
         .quo_out (div_quo[k+1])
      );
   end

   // Square root chain.
   psd_pkg::tag_type sq_tag  [0:W];
   logic [QW-1:0]    sq_rem  [0:W];
   logic [W-1:0]     sq_root [0:W];

   assign sq_tag[0].valid  = div_tag[ND].valid;
   assign sq_tag[0].region = div_tag[ND].region;
   assign sq_tag[0].sat    = div_quo[ND][QW];
   assign sq_rem[0]        = div_quo[ND][QW-1:0];
   assign sq_root[0]       = '0;

   for (genvar k = 0; k < W; k++) begin : g_sqrt
      psd_sqrt_stage #(.QW(QW), .RW(W), .SHIFT(W - 1 - k)) u_sqrt (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .tag_in   (sq_tag[k]),
         .rem_in   (sq_rem[k]),
         .root_in  (sq_root[k]),
         .tag_out  (sq_tag[k+1]),
         .rem_out  (sq_rem[k+1]),
         .root_out (sq_root[k+1])
      );
   end

   // Result; the last remainder is not needed.
   logic [W-1:0] distance;

   assign distance   = sq_tag[W].sat ? '1 : sq_root[W];
   assign rsp_tvalid = sq_tag[W].valid;
   assign rsp_tdata  = OTW'({sq_tag[W].region, distance});

endmodule

@@ rtl/psd_checker.sv @@
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the distance unit, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before transfer");

   // While a result waits, no new item enters.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted during output stall");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind point_segment_distance_unit psd_checker u_psd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

@@ bench/tb_point_segment_distance_unit.sv @@
// ----------------------------------------------------------------------------
// tb_point_segment_distance_unit
// Self-checking bench for the point to segment distance unit.
// ----------------------------------------------------------------------------
// A queue of query items, directed corner cases first and then random
// geometry, feeds a clocked driver. Each accepted item is run through an
// exact wide-integer model of the distance and region, and a clocked
// monitor compares every result transfer with the oldest prediction. Both
// sides idle in random bursts. The receiver holds off once for a long
// stretch, and the sender pauses once until all results have drained.
module tb_point_segment_distance_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW         = 32;
   localparam int RANDOM_CNT = 1730;
   localparam int TAIL_CNT   = 200;
   localparam int WD_LIMIT   = 5000;
   localparam int HOLD_AT    = 400;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_AT   = 900;

   typedef logic signed [255:0] wide_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // start_x, start_y, start_z, end_x, end_y, end_z, segment_length,
   // point_x, point_y, point_z, from the lowest bit up
   logic [319:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // distance, region, from the lowest bit up
   logic [39:0]  rsp_tdata;

   logic [319:0] query_queue[$];
   logic [33:0]  distance_queue[$];
   int           total_items;
   int           sent_cnt = 0;
   int           recv_cnt = 0;
   int           error_cnt = 0;
   int           region_cnt[4];
   bit           stim_done = 1'b0;

   point_segment_distance_unit #(.COORD_WIDTH(CW)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Squared length of the cross product of two difference vectors.
   function automatic wide_t cross_sq(wide_t x0, wide_t x1, wide_t x2,
                                      wide_t y0, wide_t y1, wide_t y2);
      wide_t c0, c1, c2;
      c0 = x1 * y2 - x2 * y1;
      c1 = x2 * y0 - x0 * y2;
      c2 = x0 * y1 - x1 * y0;
      return c0 * c0 + c1 * c1 + c2 * c2;
   endfunction

   // Exact distance and region of one query, returned as {region, distance}.
   function automatic logic [33:0] segment_distance(logic [319:0] d);
      wide_t      s[3], e[3], p[3], a[3], b[3], a2[3], b2[3];
      wide_t      dotp, aa, len, num, den, d2, cand;
      logic [31:0] root;
      psd_pkg::region_type region;
      for (int i = 0; i < 3; i++) begin
         s[i]  = wide_t'($signed(d[32*i +: 32]));
         e[i]  = wide_t'($signed(d[32*(3+i) +: 32]));
         p[i]  = wide_t'($signed(d[32*(7+i) +: 32]));
         a[i]  = e[i] - s[i];
         b[i]  = p[i] - s[i];
         a2[i] = s[i] - e[i];
         b2[i] = p[i] - e[i];
      end
      len  = wide_t'(d[192 +: 32]);
      dotp = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      aa   = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      den  = 1;
      if (dotp < 0) begin
         region = psd_pkg::REGION_START;
         num = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
      end else if (aa == 0) begin
         region = psd_pkg::REGION_INTERIOR;
         num = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
      end else if (dotp * dotp <= len * len * aa) begin
         region = psd_pkg::REGION_INTERIOR;
         num = cross_sq(a[0], a[1], a[2], b[0], b[1], b[2]);
         den = aa;
      end else begin
         d2 = a2[0] * b2[0] + a2[1] * b2[1] + a2[2] * b2[2];
         if (d2 < 0) begin
            region = psd_pkg::REGION_END;
            num = b2[0] * b2[0] + b2[1] * b2[1] + b2[2] * b2[2];
         end else begin
            region = psd_pkg::REGION_INTERIOR_END;
            num = cross_sq(a2[0], a2[1], a2[2], b2[0], b2[1], b2[2]);
            den = aa;
         end
      end
      // Bitwise root search: largest r with r*r*den <= num, saturating.
      root = '0;
      for (int bit_i = CW - 1; bit_i >= 0; bit_i--) begin
         cand = wide_t'(root | (32'd1 << bit_i));
         if (cand * cand * den <= num) root[bit_i] = 1'b1;
      end
      return {region, root};
   endfunction

   // Random coordinate: mostly modest values, sometimes full range or extremes.
   function automatic logic [31:0] rand_coord();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      if (sel < 8) return $urandom;
      if (sel == 8) return 32'h8000_0000;
      return 32'h7FFF_FFFF;
   endfunction

   function automatic logic [319:0] pack_query(logic [31:0] sx, sy, sz, ex, ey, ez,
                                               logic [31:0] len, px, py, pz);
      return {pz, py, px, len, ez, ey, ex, sz, sy, sx};
   endfunction

   // Stimulus: directed corner cases, then random geometry.
   initial begin
      logic [31:0] c[10];
      real         dx, dy, dz, seg_len;
      int unsigned sel;
      // Degenerate segment, start equals end.
      query_queue.push_back(pack_query(5, 6, 7, 5, 6, 7, 0, 100, 200, 300));
      query_queue.push_back(pack_query(0, 0, 0, 0, 0, 0, '1, '1, '1, '1));
      // Projection exactly zero is not the start cap.
      query_queue.push_back(pack_query(0, 0, 0, 32'h10000, 0, 0, 32'h10000,
                                       0, 32'h50000, 0));
      // Projection exactly equal to the given length.
      query_queue.push_back(pack_query(0, 0, 0, 32'h10000, 0, 0, 32'h30000,
                                       32'h30000, 1, 0));
      // Start cap, end cap, and interior measured from the end point.
      query_queue.push_back(pack_query(0, 0, 0, 32'h10000, 0, 0, 32'h10000,
                                       -32'sh20000, 3, 0));
      query_queue.push_back(pack_query(0, 0, 0, 32'h10000, 0, 0, 32'h10000,
                                       32'h40000, 0, 32'h10000));
      query_queue.push_back(pack_query(0, 0, 0, 32'h40000, 0, 0, 32'h10000,
                                       32'h20000, 32'h8000, 0));
      // Length zero against a real segment.
      query_queue.push_back(pack_query(1, 2, 3, 32'h1000, 9, 9, 0, 50, 50, 50));
      // Extremes: saturation and full-range coordinates.
      query_queue.push_back(pack_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      query_queue.push_back(pack_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1,
                                       0, 0, 0));
      query_queue.push_back(pack_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1,
                                       32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
      query_queue.push_back(pack_query('1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
      query_queue.push_back(pack_query('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      query_queue.push_back(pack_query(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
                                       32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
      for (int n = 0; n < RANDOM_CNT; n++) begin
         for (int k = 0; k < 10; k++) c[k] = rand_coord();
         // Point near the segment so all regions are reached.
         if ($urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 3; k++)
               c[7+k] = c[k] + 32'($signed(c[3+k] - c[k]) >>> $urandom_range(0, 2))
                      + 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
         end
         dx = real'($signed(c[3])) - real'($signed(c[0]));
         dy = real'($signed(c[4])) - real'($signed(c[1]));
         dz = real'($signed(c[5])) - real'($signed(c[2]));
         seg_len = $sqrt(dx * dx + dy * dy + dz * dz);
         sel = $urandom_range(0, 7);
         if (sel < 4 && seg_len < 4.0e9) c[6] = 32'($rtoi(seg_len));
         else if (sel == 4 && seg_len < 8.0e9) c[6] = 32'($rtoi(seg_len / 2.0));
         else if (sel == 5) c[6] = '1;
         else if (sel == 6) c[6] = 0;
         if ($urandom_range(0, 30) == 0) for (int k = 0; k < 3; k++) c[3+k] = c[k];
         query_queue.push_back(pack_query(c[0], c[1], c[2], c[3], c[4], c[5],
                                          c[6], c[7], c[8], c[9]));
      end
      total_items = query_queue.size();
      stim_done = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (sent_cnt == total_items && distance_queue.size() == 0);
      repeat (200) @(posedge clock);
      $display("Checked %0d results: start cap %0d, interior %0d, end cap %0d,",
               recv_cnt, region_cnt[0], region_cnt[1], region_cnt[2]);
      $display("interior from end %0d, with random idling and a long output stall.",
               region_cnt[3]);
      if (error_cnt == 0 && recv_cnt == total_items)
         $display("** point_segment_distance_unit: PASSED **");
      else
         $display("** point_segment_distance_unit: FAILED **");
      $finish;
   end

   // Driver: offers queued items, idles in bursts, pauses once to drain.
   int  send_gap = 0;
   bit  drained  = 1'b0;
   always @(posedge clock) begin
      logic valid_n;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            distance_queue.push_back(segment_distance(query_queue.pop_front()));
            sent_cnt++;
            if (sent_cnt < total_items - TAIL_CNT && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 9);
         end
         valid_n = 1'b0;
         if (send_gap > 0) send_gap--;
         else if (sent_cnt == DRAIN_AT && !drained && distance_queue.size() != 0)
            valid_n = 1'b0;
         else if (query_queue.size() != 0) begin
            if (sent_cnt == DRAIN_AT) drained = 1'b1;
            valid_n = 1'b1;
            req_tdata <= query_queue[0];
         end
         req_tvalid <= valid_n;
      end
   end

   // Receiver: random stalls, one long hold-off, none in the tail.
   int recv_gap  = 0;
   int hold_left = 0;
   bit held      = 1'b0;
   always @(posedge clock) begin
      if (!reset) begin
         if (recv_cnt >= HOLD_AT && !held) begin
            held = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            if (recv_cnt < total_items - TAIL_CNT && $urandom_range(0, 9) == 0)
               recv_gap = $urandom_range(1, 9);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: compares each result transfer with the oldest prediction.
   always @(posedge clock) begin
      logic [33:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         recv_cnt++;
         if (distance_queue.size() == 0) begin
            $error("result transfer with no prediction pending: %h", rsp_tdata);
            error_cnt++;
         end else begin
            want = distance_queue.pop_front();
            region_cnt[want[33:32]]++;
            if (rsp_tdata[31:0] !== want[31:0]) begin
               $error("distance: expected %h, actual %h", want[31:0], rsp_tdata[31:0]);
               error_cnt++;
            end
            if (rsp_tdata[33:32] !== want[33:32]) begin
               $error("region: expected %0d, actual %0d", want[33:32], rsp_tdata[33:32]);
               error_cnt++;
            end
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any transfer.
   int quiet_cnt = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cnt <= 0;
      else if (quiet_cnt >= WD_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles.", WD_LIMIT);
         $display("** point_segment_distance_unit: FAILED **");
         $finish;
      end else
         quiet_cnt <= quiet_cnt + 1;
   end

endmodule
